FILE: rtl/typed_field_to_float32_macros.svh
// assertion macros for the typed field to float32 converter
// no dependencies
`ifndef TYPED_FIELD_TO_FLOAT32_MACROS_SVH
`define TYPED_FIELD_TO_FLOAT32_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TF_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define TF_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TF_ASSERT_IMP(label, clk, rst, a, c)
`define TF_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

FILE: rtl/tf2f_pkg.sv
// shared types and constants for the typed field to float32 converter
// no dependencies
package tf2f_pkg;
  localparam logic [3:0] TYPE_INT8    = 4'd0;
  localparam logic [3:0] TYPE_UINT8   = 4'd1;
  localparam logic [3:0] TYPE_INT16   = 4'd2;
  localparam logic [3:0] TYPE_UINT16  = 4'd3;
  localparam logic [3:0] TYPE_INT32   = 4'd4;
  localparam logic [3:0] TYPE_UINT32  = 4'd5;
  localparam logic [3:0] TYPE_FLOAT32 = 4'd6;
  localparam logic [3:0] TYPE_FLOAT64 = 4'd7;

  // what the front stage hands to the rounding stage
  typedef struct packed {
    logic        zero;      // result is signed zero
    logic        special;   // result is taken from spec_bits
    logic [31:0] spec_bits;
    logic        sign;
    logic [52:0] mant;      // nonzero value = mant * 2^exp
    logic [11:0] exp;       // signed exponent
  } tf2f_unpk_t;

  // leading one position of a 53-bit value
  function automatic logic [5:0] tf2f_msb(input logic [52:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 53; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction
endpackage

FILE: rtl/tf2f_stream_if.sv
// valid/ready channel carrying one payload
// no dependencies
interface tf2f_stream_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tf2f_unpack.sv
// byte gather and classification into sign, mantissa and exponent
// depends on tf2f_pkg
module tf2f_unpack import tf2f_pkg::*; (
  input  logic [63:0] raw_bytes,
  input  logic [3:0]  field_type,
  input  logic        little_endian,
  output tf2f_unpk_t  unpk
);
  logic [15:0] v16;
  logic [31:0] v32;
  logic [63:0] v64;
  logic [7:0]  v8;
  logic [10:0] ex;
  logic [51:0] frac;

  always_comb begin
    v8 = raw_bytes[7:0];
    for (int i = 0; i < 2; i++) begin
      v16[8*i +: 8] = little_endian ? raw_bytes[8*i +: 8] : raw_bytes[8*(1-i) +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      v32[8*i +: 8] = little_endian ? raw_bytes[8*i +: 8] : raw_bytes[8*(3-i) +: 8];
    end
    for (int i = 0; i < 8; i++) begin
      v64[8*i +: 8] = little_endian ? raw_bytes[8*i +: 8] : raw_bytes[8*(7-i) +: 8];
    end
    ex   = v64[62:52];
    frac = v64[51:0];
    unpk = '0;
    case (field_type)
      TYPE_INT8: begin
        unpk.sign = v8[7];
        unpk.mant = 53'(v8[7] ? 8'(-v8) : v8);
        unpk.zero = v8 == '0;
      end
      TYPE_UINT8: begin
        unpk.mant = 53'(v8);
        unpk.zero = v8 == '0;
      end
      TYPE_INT16: begin
        unpk.sign = v16[15];
        unpk.mant = 53'(v16[15] ? 16'(-v16) : v16);
        unpk.zero = v16 == '0;
      end
      TYPE_UINT16: begin
        unpk.mant = 53'(v16);
        unpk.zero = v16 == '0;
      end
      TYPE_INT32: begin
        unpk.sign = v32[31];
        unpk.mant = 53'(v32[31] ? 32'(-v32) : v32);
        unpk.zero = v32 == '0;
      end
      TYPE_UINT32: begin
        unpk.mant = 53'(v32);
        unpk.zero = v32 == '0;
      end
      TYPE_FLOAT32: begin
        unpk.special   = 1'b1;
        unpk.spec_bits = v32;
      end
      TYPE_FLOAT64: begin
        unpk.sign = v64[63];
        if (ex == 11'h7FF) begin
          unpk.special = 1'b1;
          unpk.spec_bits = (frac == '0) ? {v64[63], 31'h7F80_0000}
                                        : {v64[63], 8'hFF, frac[51:29]} | 32'h7FC0_0000;
        end else if (ex == '0) begin
          unpk.zero = frac == '0;
          unpk.mant = {1'b0, frac};
          unpk.exp  = -12'sd1074;
        end else begin
          unpk.mant = {1'b1, frac};
          unpk.exp  = 12'({1'b0, ex}) - 12'd1075;
        end
      end
      default: begin
        unpk.special = 1'b1;
      end
    endcase
  end
endmodule

FILE: rtl/tf2f_round.sv
// normalise and round to nearest even into a float32 pattern
// depends on tf2f_pkg
module tf2f_round import tf2f_pkg::*; (
  input  tf2f_unpk_t  unpk,
  output logic [31:0] float_bits
);
  logic [5:0]         p;
  logic signed [13:0] biased;
  logic signed [13:0] s;
  logic [52:0]        q;
  logic [53:0]        qr;
  logic [52:0]        rem;
  logic [52:0]        half;
  logic [7:0]         sh;
  logic signed [13:0] bexp;
  logic [31:0]        mag;

  always_comb begin
    p      = tf2f_msb(unpk.mant);
    biased = 14'(p) + 14'(signed'(unpk.exp)) + 14'sd127;
    s      = (biased >= 1) ? 14'(p) - 14'sd23 : -(14'(signed'(unpk.exp)) + 14'sd149);
    q = '0;
    rem = '0;
    half = '0;
    // mantissa is below 2^53, so any shift of 53 or more leaves nothing
    if (s <= 0) begin
      sh = 8'(-s);
      q  = (sh > 8'd52) ? '0 : unpk.mant << sh;
    end else if (s <= 14'sd54) begin
      sh   = 8'(s);
      q    = unpk.mant >> sh;
      rem  = unpk.mant & ((53'd1 << sh) - 53'd1);
      if (sh == 8'd54) rem = unpk.mant;
      if (sh == 8'd54) q = '0;
      half = (sh > 8'd53) ? '0 : 53'd1 << (sh - 8'd1);
    end else begin
      sh = '0;
    end
    qr = {1'b0, q};
    if (s > 0 && s <= 14'sd54) begin
      if (sh == 8'd54) begin
        qr = '0;
      end else if (rem > half || (rem == half && q[0])) begin
        qr = {1'b0, q} + 54'd1;
      end
    end
    bexp = biased;
    if (biased >= 1) begin
      if (qr == 54'd1 << 24) begin
        qr   = qr >> 1;
        bexp = biased + 14'sd1;
      end
      mag = (bexp >= 14'sd255) ? 32'h7F80_0000 : {1'b0, bexp[7:0], qr[22:0]};
    end else begin
      mag = qr[31:0];
    end
    if (unpk.special)   float_bits = unpk.spec_bits;
    else if (unpk.zero) float_bits = {unpk.sign, 31'd0};
    else                float_bits = mag | {unpk.sign, 31'd0};
  end
endmodule

FILE: rtl/typed_field_to_float32.sv
// typed binary field to float32 converter, top level
// depends on tf2f_pkg, tf2f_stream_if, tf2f_unpack, tf2f_round and the macro header
//
//   channel   | dir | payload
//   in_ch     | in  | raw_bytes[63:0], field_type[3:0]
//   out_ch    | out | float_bits[31:0]
//   cfg       | in  | cfg_we, cfg_data (file_little_endian)
// one request per cycle while out_ch is not stalled; input register, then unpack and
// rounding logic, then result register, from which out_ch offers the result
// rst clears both valid flags and sets little-endian order
// a stalled result holds the result register; the input register still takes a
// request when the result register is free or being drained
`include "typed_field_to_float32_macros.svh"
module typed_field_to_float32 import tf2f_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  tf2f_stream_if.sink   in_ch,
  tf2f_stream_if.source out_ch,
  input  logic         cfg_we,
  input  logic         cfg_data
);
  logic        little_endian;
  logic        s1_valid;
  logic [63:0] s1_raw;
  logic [3:0]  s1_type;
  logic        s2_valid;
  logic [31:0] s2_bits;
  tf2f_unpk_t  unpk;
  logic [31:0] s1_bits;
  logic        s2_free;
  logic        s1_free;

  assign s2_free      = !s2_valid || out_ch.ready;
  assign s1_free      = !s1_valid || s2_free;
  assign in_ch.ready  = s1_free;
  assign out_ch.valid = s2_valid;
  assign out_ch.data  = s2_bits;

  tf2f_unpack u_unpack (
    .raw_bytes(s1_raw), .field_type(s1_type), .little_endian(little_endian), .unpk(unpk)
  );
  tf2f_round u_round (.unpk(unpk), .float_bits(s1_bits));

  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b1;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (cfg_we) little_endian <= cfg_data;
      if (s1_free) s1_valid <= in_ch.valid;
      if (s2_free) s2_valid <= s1_valid;
    end
    if (s1_free && in_ch.valid) begin
      s1_raw  <= in_ch.data[67:4];
      s1_type <= in_ch.data[3:0];
    end
    if (s2_free && s1_valid) s2_bits <= s1_bits;
  end

  `TF_ASSERT_NXT(a_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
  `TF_ASSERT_NXT(a_flow, clk, rst, s1_valid && s2_free, s2_valid)
  `TF_ASSERT_IMP(a_ready, clk, rst, !in_ch.ready, s1_valid && s2_valid)
endmodule
